// ===== design/bufpool_pkg.sv =====
// ----------------------------------------------------------------------------
// bufpool_pkg
// Shared types and codes for the buffer pool free/ready list block.
// ----------------------------------------------------------------------------
package bufpool_pkg;

  localparam int POOL_SIZE = 16;
  localparam int IDX_W     = 4;
  localparam int PTR_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_PUBLISH = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_RECLAIM = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] buf_index;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] ready_count;
  } out_word_t;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(POOL_SIZE - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/buffer_pool_free_and_ready_fifo.sv =====
// ----------------------------------------------------------------------------
// buffer_pool_free_and_ready_fifo
// Frame buffer pool kept as two register-ring FIFO lists: free and ready.
// ----------------------------------------------------------------------------
// Takes one operation word per cycle (acquire, publish, consume, release) and
// returns one result word per operation, in order. A word is captured in an
// input register, the list update and result are computed combinationally from
// that register, and the result lands in the output register, which drives
// out_valid; sustained rate one word per clock as long as
// out_ready keeps up. The list rings are flip-flop arrays with one
// head read and one tail write per list per cycle. After reset the free list
// holds every index in ascending order and the ready list is empty; acquire
// on an empty free list reclaims the oldest ready buffer.
module buffer_pool_free_and_ready_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bufpool_pkg::in_word_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bufpool_pkg::out_word_t out_data
);
  import bufpool_pkg::*;

  // input stage
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      move;

  // list state
  logic [IDX_W-1:0] free_ring_r  [POOL_SIZE];
  logic [IDX_W-1:0] ready_ring_r [POOL_SIZE];
  logic [PTR_W-1:0] free_head_r, free_tail_r, ready_head_r, ready_tail_r;
  logic [CNT_W-1:0] free_total_r, ready_total_r;

  logic [PTR_W-1:0] free_head_nxt, free_tail_nxt, ready_head_nxt, ready_tail_nxt;
  logic [CNT_W-1:0] free_total_nxt, ready_total_nxt;
  logic             free_we, ready_we;
  logic [IDX_W-1:0] res_idx;
  logic [1:0]       res_status;

  // output stage
  logic      out_valid_r;
  out_word_t out_word_r;

  assign move     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || move;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_comb begin
    free_head_nxt   = free_head_r;
    free_tail_nxt   = free_tail_r;
    free_total_nxt  = free_total_r;
    ready_head_nxt  = ready_head_r;
    ready_tail_nxt  = ready_tail_r;
    ready_total_nxt = ready_total_r;
    free_we         = 1'b0;
    ready_we        = 1'b0;
    res_idx         = '0;
    res_status      = ST_DONE;
    unique case (s1_word_r.op)
      OP_ACQUIRE: begin
        if (free_total_r != '0) begin
          res_idx        = free_ring_r[free_head_r];
          free_head_nxt  = ptr_advance(free_head_r);
          free_total_nxt = free_total_r - CNT_W'(1);
        end else if (ready_total_r != '0) begin
          // free list dry: take back the oldest ready buffer
          res_idx         = ready_ring_r[ready_head_r];
          ready_head_nxt  = ptr_advance(ready_head_r);
          ready_total_nxt = ready_total_r - CNT_W'(1);
          res_status      = ST_RECLAIM;
        end else begin
          res_status = ST_NONE;
        end
      end
      OP_PUBLISH: begin
        if (ready_total_r >= CNT_W'(POOL_SIZE)) begin
          res_status = ST_FULL;
        end else begin
          ready_we        = 1'b1;
          ready_tail_nxt  = ptr_advance(ready_tail_r);
          ready_total_nxt = ready_total_r + CNT_W'(1);
        end
      end
      OP_CONSUME: begin
        if (ready_total_r != '0) begin
          res_idx         = ready_ring_r[ready_head_r];
          ready_head_nxt  = ptr_advance(ready_head_r);
          ready_total_nxt = ready_total_r - CNT_W'(1);
        end else begin
          res_status = ST_NONE;
        end
      end
      OP_RELEASE: begin
        if (free_total_r >= CNT_W'(POOL_SIZE)) begin
          res_status = ST_FULL;
        end else begin
          free_we        = 1'b1;
          free_tail_nxt  = ptr_advance(free_tail_r);
          free_total_nxt = free_total_r + CNT_W'(1);
        end
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
  end

  // list pointers and counts: advance only when the word moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      free_tail_r   <= '0;
      free_total_r  <= CNT_W'(POOL_SIZE);
      ready_head_r  <= '0;
      ready_tail_r  <= '0;
      ready_total_r <= '0;
    end else if (move) begin
      free_head_r   <= free_head_nxt;
      free_tail_r   <= free_tail_nxt;
      free_total_r  <= free_total_nxt;
      ready_head_r  <= ready_head_nxt;
      ready_tail_r  <= ready_tail_nxt;
      ready_total_r <= ready_total_nxt;
    end
  end

  // free ring starts full with ascending indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        free_ring_r[i] <= IDX_W'(i);
      end
    end else if (move && free_we) begin
      free_ring_r[free_tail_r] <= s1_word_r.buf_index;
    end
  end

  always_ff @(posedge clk) begin
    if (move && ready_we) begin
      ready_ring_r[ready_tail_r] <= s1_word_r.buf_index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_word_r.out_index   <= res_idx;
      out_word_r.status      <= res_status;
      out_word_r.free_count  <= free_total_nxt;
      out_word_r.ready_count <= ready_total_nxt;
    end
  end

endmodule

// ===== tb/sv/buffer_pool_free_and_ready_fifo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_free_and_ready_fifo_tb
// Drives acquire/publish/consume/release words into the buffer pool and checks
// every result word against a predictor of the free and ready lists, under
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module buffer_pool_free_and_ready_fifo_tb;
  import bufpool_pkg::*;

  localparam real HALF_PERIOD    = 6.0;
  localparam int  RANDOM_WORDS   = 1225;
  localparam int  IDLE_PCT       = 35;
  localparam int  CALM_FIRST     = 300;
  localparam int  CALM_LAST      = 700;
  localparam int  HOLD_AFTER     = 900;
  localparam int  HOLD_CYCLES    = 240;
  localparam int  DRAIN_CYCLES   = 8;
  localparam int  WATCHDOG_LIMIT = 2000;

  typedef enum int {MIX_EVEN, MIX_FILL, MIX_STARVE, MIX_DRAIN} mix_t;

  typedef struct packed {
    logic [POOL_SIZE-1:0][IDX_W-1:0] free_ring;
    logic [POOL_SIZE-1:0][IDX_W-1:0] ready_ring;
    logic [PTR_W-1:0]                free_head, free_tail, ready_head, ready_tail;
    logic [CNT_W-1:0]                free_total, ready_total;
  } pool_state_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  pool_state_t      live_pool;
  pool_state_t      plan_pool;
  in_word_t         pending_q[$];
  out_word_t        due_results[$];
  logic [IDX_W-1:0] writer_q[$];
  logic [IDX_W-1:0] reader_q[$];

  int   total_words  = 0;
  int   words_in     = 0;
  int   words_out    = 0;
  int   err_cnt      = 0;
  int   cycle_no     = 0;
  int   quiet_cycles = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  int   status_seen[4];

  wire calm = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

  buffer_pool_free_and_ready_fifo uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % POOL_SIZE);
  endfunction

  function automatic pool_state_t fresh_pool();
    pool_state_t s;
    int          i;
    s = '0;
    for (i = 0; i < POOL_SIZE; i++) begin
      s.free_ring[i] = IDX_W'(i);
    end
    s.free_total = CNT_W'(POOL_SIZE);
    return s;
  endfunction

  // One list operation on the pool; returns the result word it produces.
  function automatic out_word_t pool_step(inout pool_state_t s, input in_word_t w);
    out_word_t r;
    r        = '0;
    r.status = ST_DONE;
    case (w.op)
      OP_ACQUIRE: begin
        if (s.free_total != '0) begin
          r.out_index  = s.free_ring[s.free_head];
          s.free_head  = next_slot(s.free_head);
          s.free_total = s.free_total - CNT_W'(1);
        end else if (s.ready_total != '0) begin
          // free list dry: take back the oldest ready buffer
          r.out_index   = s.ready_ring[s.ready_head];
          s.ready_head  = next_slot(s.ready_head);
          s.ready_total = s.ready_total - CNT_W'(1);
          r.status      = ST_RECLAIM;
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_PUBLISH: begin
        if (s.ready_total >= CNT_W'(POOL_SIZE)) begin
          r.status = ST_FULL;
        end else begin
          s.ready_ring[s.ready_tail] = w.buf_index;
          s.ready_tail               = next_slot(s.ready_tail);
          s.ready_total              = s.ready_total + CNT_W'(1);
        end
      end
      OP_CONSUME: begin
        if (s.ready_total != '0) begin
          r.out_index   = s.ready_ring[s.ready_head];
          s.ready_head  = next_slot(s.ready_head);
          s.ready_total = s.ready_total - CNT_W'(1);
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_RELEASE: begin
        if (s.free_total >= CNT_W'(POOL_SIZE)) begin
          r.status = ST_FULL;
        end else begin
          s.free_ring[s.free_tail] = w.buf_index;
          s.free_tail              = next_slot(s.free_tail);
          s.free_total             = s.free_total + CNT_W'(1);
        end
      end
    endcase
    r.free_count  = s.free_total;
    r.ready_count = s.ready_total;
    return r;
  endfunction

  // Queue a word and track which buffers the writer and reader now hold.
  function automatic out_word_t plan_word(input logic [1:0] op, input logic [IDX_W-1:0] idx);
    in_word_t  w;
    out_word_t r;
    w.op        = op;
    w.buf_index = idx;
    pending_q.push_back(w);
    r = pool_step(plan_pool, w);
    if (r.status == ST_DONE || r.status == ST_RECLAIM) begin
      if (op == OP_ACQUIRE) begin
        writer_q.push_back(r.out_index);
      end else if (op == OP_CONSUME) begin
        reader_q.push_back(r.out_index);
      end
    end
    return r;
  endfunction

  initial begin : stimulus
    int               n;
    int               roll;
    int               pos;
    int               left_in_mix;
    mix_t             mix;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    out_word_t        r;

    live_pool   = fresh_pool();
    plan_pool   = fresh_pool();
    status_seen = '{default: 0};

    // release into a full free list, consume from an empty ready list
    void'(plan_word(OP_RELEASE, 4'hF));
    void'(plan_word(OP_CONSUME, 4'h0));
    void'(plan_word(OP_ACQUIRE, 4'h0));
    void'(plan_word(OP_PUBLISH, 4'h0));
    void'(plan_word(OP_CONSUME, 4'h0));
    void'(plan_word(OP_RELEASE, 4'h0));
    // empty the free list, then acquire with both lists empty
    for (n = 0; n < POOL_SIZE; n++) begin
      void'(plan_word(OP_ACQUIRE, 4'h0));
    end
    void'(plan_word(OP_ACQUIRE, 4'h0));
    // reclaim the oldest ready buffer
    void'(plan_word(OP_PUBLISH, 4'hF));
    void'(plan_word(OP_ACQUIRE, 4'h0));
    writer_q.delete();
    for (n = 0; n < POOL_SIZE; n++) begin
      writer_q.push_back(IDX_W'(n));
    end

    left_in_mix = 0;
    mix         = MIX_EVEN;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (left_in_mix == 0) begin
        mix         = mix_t'($urandom_range(3));
        left_in_mix = $urandom_range(80, 20);
      end
      left_in_mix--;
      if ($urandom_range(99) < 5) begin
        void'(plan_word(2'($urandom_range(3)), IDX_W'($urandom_range(15))));
      end else begin
        roll = $urandom_range(99);
        case (mix)
          MIX_FILL:   op = (roll < 30) ? OP_ACQUIRE : (roll < 80) ? OP_PUBLISH :
                           (roll < 90) ? OP_CONSUME : OP_RELEASE;
          MIX_STARVE: op = (roll < 60) ? OP_ACQUIRE : (roll < 80) ? OP_PUBLISH :
                           (roll < 90) ? OP_CONSUME : OP_RELEASE;
          MIX_DRAIN:  op = (roll < 10) ? OP_ACQUIRE : (roll < 20) ? OP_PUBLISH :
                           (roll < 60) ? OP_CONSUME : OP_RELEASE;
          default:    op = 2'(roll % 4);
        endcase
        // push a buffer the caller holds; now and then a stray index
        idx = IDX_W'($urandom_range(15));
        pos = -1;
        if (op == OP_PUBLISH && writer_q.size() != 0 && $urandom_range(9) != 0) begin
          pos = $urandom_range(writer_q.size() - 1);
          idx = writer_q[pos];
        end else if (op == OP_RELEASE && reader_q.size() != 0 && $urandom_range(9) != 0) begin
          pos = $urandom_range(reader_q.size() - 1);
          idx = reader_q[pos];
        end
        r = plan_word(op, idx);
        if (pos >= 0 && r.status != ST_FULL) begin
          if (op == OP_PUBLISH) begin
            writer_q.delete(pos);
          end else begin
            reader_q.delete(pos);
          end
        end
      end
    end
    total_words = pending_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (words_in < total_words || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operations in, %0d results checked: %0d done, %0d none available,",
             words_in, words_out, status_seen[ST_DONE], status_seen[ST_NONE]);
    $display("%0d reclaimed, %0d refused on a full list; one %0d-cycle output stall",
             status_seen[ST_RECLAIM], status_seen[ST_FULL], HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("buffer_pool_free_and_ready_fifo_tb: PASS");
    end else begin
      $display("buffer_pool_free_and_ready_fifo_tb: FAIL");
    end
    $finish;
  end

  // Input side: predict at acceptance, then offer the next word or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(pool_step(live_pool, in_data));
        words_in <= words_in + 1;
      end
      if (!in_valid || in_ready) begin
        // keep offering while the output is held off
        if (pending_q.size() != 0 &&
            (calm || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_out <= words_out + 1;
      status_seen[out_data.status]++;
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_data);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_data.out_index !== want.out_index) begin
          $error("out_index: expected %0d, got %0d", want.out_index, out_data.out_index);
          err_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_cnt++;
        end
        if (out_data.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, out_data.free_count);
          err_cnt++;
        end
        if (out_data.ready_count !== want.ready_count) begin
          $error("ready_count: expected %0d, got %0d", want.ready_count, out_data.ready_count);
          err_cnt++;
        end
      end
    end
  end

  // Stop if no word moves on either channel for too long.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("buffer_pool_free_and_ready_fifo_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
